// ----- hdl/pslt_pkg.sv -----
// Package: widths, payload structs, status codes and controller command encodings.
package pslt_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 7;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int ID_W    = 32;
    localparam int COLOR_W = 8;
    localparam int DIST_W  = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;

    localparam logic [POS_W-1:0]     CAP_RESET    = POS_W'(64);
    localparam logic [PADDR_W-3:0]   REG_CAPACITY = '0;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_SORTED = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [POS_W-1:0]   position;
        logic [ID_W-1:0]    entry_id;
        logic [COLOR_W-1:0] entry_color;
        logic [DIST_W-1:0]  entry_dist;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [ID_W-1:0]    read_id;
        logic [COLOR_W-1:0] read_color;
        logic [DIST_W-1:0]  read_dist;
        logic [POS_W-1:0]   placed_at;
        logic [POS_W-1:0]   item_count;
    } t_res;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COLOR_W-1:0] color;
        logic [DIST_W-1:0]  distance;
    } t_entry;

    // read address source
    typedef enum logic [1:0] {
        RA_PTR,
        RA_PTR_M1,
        RA_POS
    } t_ra;

    // write source and address
    typedef enum logic [2:0] {
        WR_NONE,
        WR_UP,
        WR_DN,
        WR_PLACE,
        WR_POS
    } t_wr;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COUNT,
        PTR_POS1,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        PL_HOLD,
        PL_POS,
        PL_TAG,
        PL_COUNT
    } t_pl_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic    latch;
        logic    rd_en;
        t_ra     ra;
        t_wr     wr;
        t_ptr_op ptr;
        t_pl_op  place;
        t_cnt_op cnt;
        logic    st_load;
        t_status st_code;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            ins_bad;
        logic            pos_bad;
        logic            more_fwd;
        logic            more_up;
        logic            pend;
        logic            hit;
        logic            tag_last;
    } t_stat;

endpackage

// ----- hdl/positional_sorted_list_table_core.sv -----
// Top level: list table with capacity register, controller and datapath.
//
// A request is taken at a clock edge where start is high and busy is low; its
// fields sit on i_req. Exactly one result per request appears on o_res for one
// cycle with o_strobe high; the receiver cannot stall it.
// Entries live in a single-port-write, single-port-read memory with a registered
// read, so insert, remove and sorted search walk the list one entry per cycle.
// Busy drops in the same cycle the strobe rises; the next request may be taken
// at the end of that cycle. Read, write, errors and unknown opcodes go from
// decode straight to the result. Insert at P shifts the entries from the top
// down to P, then places the new one; remove at P shifts the entries above P down.
// Sorted insert searches forward for the first entry whose distance is not less
// than the new one, shifts the entries from there up and places it there, or
// appends it at the end when none is found.
// Reset empties the list (count zero) and sets capacity to 64; the entry memory
// is not cleared, as no request reads beyond count. Capacity is written over the
// APB port at byte address 0 and should only change while the block is idle.
module positional_sorted_list_table_core import pslt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    output logic               o_strobe,
    output t_res               o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [POS_W-1:0] r_cap;
    logic             cap_sel;
    t_cmd             cmd;
    t_stat            stat;

    assign cap_sel = (paddr[PADDR_W-1:2] == REG_CAPACITY);
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? APB_DW'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && cap_sel) begin
            r_cap <= pwdata[POS_W-1:0];
        end
    end

    pslt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pslt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_capacity (r_cap),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_strobe   (o_strobe),
        .o_res      (o_res)
    );

endmodule

// ----- hdl/pslt_dp.sv -----
// Datapath: entry memory, count, walk pointer, request latch and result register.
module pslt_dp import pslt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  logic [POS_W-1:0] i_capacity,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic             o_strobe,
    output t_res             o_res
);

    t_entry             r_mem [DEPTH];
    t_entry             r_rd_data;
    t_req               r_req;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_ptr;
    logic [CNT_W-1:0]   r_place;
    logic [IDX_W-1:0]   r_tag;
    logic               r_pend;
    t_status            r_status;
    logic               r_strobe;
    t_res               r_res;

    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cap_ext;
    logic [IDX_W-1:0]   ra;
    logic [IDX_W-1:0]   wa;
    logic               we;
    t_entry             wd;
    t_entry             new_entry;
    logic               ok;

    assign cnt_ext   = CMP_W'(r_count);
    assign pos_ext   = CMP_W'(r_req.position);
    assign cap_ext   = CMP_W'(i_capacity);
    assign new_entry = '{id: r_req.entry_id, color: r_req.entry_color,
                         distance: r_req.entry_dist};

    always_comb begin
        o_stat.op       = r_req.opcode;
        o_stat.full     = (cnt_ext >= cap_ext) || (r_count >= CNT_W'(DEPTH));
        o_stat.ins_bad  = pos_ext > cnt_ext;
        o_stat.pos_bad  = pos_ext >= cnt_ext;
        o_stat.more_fwd = r_ptr < r_count;
        o_stat.more_up  = r_ptr > r_place;
        o_stat.pend     = r_pend;
        o_stat.hit      = r_rd_data.distance >= r_req.entry_dist;
        o_stat.tag_last = (CNT_W'(r_tag) + CNT_W'(1)) == r_count;
    end

    always_comb begin
        case (i_cmd.ra)
            RA_PTR:    ra = IDX_W'(r_ptr);
            RA_PTR_M1: ra = IDX_W'(r_ptr - CNT_W'(1));
            RA_POS:    ra = IDX_W'(r_req.position);
            default:   ra = IDX_W'(r_ptr);
        endcase
    end

    always_comb begin
        we = 1'b0;
        wa = r_tag;
        wd = r_rd_data;
        case (i_cmd.wr)
            WR_UP: begin
                we = r_pend;
                wa = r_tag + IDX_W'(1);
            end
            WR_DN: begin
                we = r_pend;
                wa = r_tag - IDX_W'(1);
            end
            WR_PLACE: begin
                we = 1'b1;
                wa = IDX_W'(r_place);
                wd = new_entry;
            end
            WR_POS: begin
                we = 1'b1;
                wa = IDX_W'(r_req.position);
                wd = new_entry;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[ra];
            r_tag     <= ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        case (i_cmd.ptr)
            PTR_ZERO:  r_ptr <= '0;
            PTR_COUNT: r_ptr <= r_count;
            PTR_POS1:  r_ptr <= CNT_W'(r_req.position) + CNT_W'(1);
            PTR_INC:   r_ptr <= r_ptr + CNT_W'(1);
            PTR_DEC:   r_ptr <= r_ptr - CNT_W'(1);
            default:   r_ptr <= r_ptr;
        endcase
        case (i_cmd.place)
            PL_POS:   r_place <= CNT_W'(r_req.position);
            PL_TAG:   r_place <= CNT_W'(r_tag);
            PL_COUNT: r_place <= r_count;
            default:  r_place <= r_place;
        endcase
        if (i_cmd.st_load) begin
            r_status <= i_cmd.st_code;
        end
    end

    assign ok = (r_status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res.status     <= r_status;
            r_res.read_id    <= (r_req.opcode == OP_READ && ok) ? r_rd_data.id : '0;
            r_res.read_color <= (r_req.opcode == OP_READ && ok) ? r_rd_data.color : '0;
            r_res.read_dist  <= (r_req.opcode == OP_READ && ok) ? r_rd_data.distance : '0;
            r_res.placed_at  <= (r_req.opcode == OP_SORTED && ok) ? POS_W'(r_place) : '0;
            r_res.item_count <= POS_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_pend   <= i_cmd.rd_en;
            r_strobe <= i_cmd.emit;
            case (i_cmd.cnt)
                CNT_INC: r_count <= r_count + CNT_W'(1);
                CNT_DEC: r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ----- hdl/pslt_ctrl.sv -----
// Controller: sequences decode, search, shift and place steps for one item.
module pslt_ctrl import pslt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_SHUP,
        S_SHDN,
        S_PLACE,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        cmd.latch   = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.ra      = RA_PTR;
        cmd.wr      = WR_NONE;
        cmd.ptr     = PTR_HOLD;
        cmd.place   = PL_HOLD;
        cmd.cnt     = CNT_HOLD;
        cmd.st_load = 1'b0;
        cmd.st_code = ST_OK;
        cmd.emit    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.latch = 1'b1;
                    n_busy    = 1'b1;
                    n_state   = S_DECODE;
                end
            end

            S_DECODE: begin
                cmd.st_load = 1'b1;
                n_state     = S_FINISH;
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            cmd.st_code = ST_FULL;
                        end else if (i_stat.ins_bad) begin
                            cmd.st_code = ST_BADPOS;
                        end else begin
                            cmd.place = PL_POS;
                            cmd.ptr   = PTR_COUNT;
                            n_state   = S_SHUP;
                        end
                    end
                    OP_SORTED: begin
                        if (i_stat.full) begin
                            cmd.st_code = ST_FULL;
                        end else begin
                            cmd.ptr = PTR_ZERO;
                            n_state = S_SEARCH;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.pos_bad) begin
                            cmd.st_code = ST_BADPOS;
                        end else begin
                            cmd.ptr = PTR_POS1;
                            n_state = S_SHDN;
                        end
                    end
                    OP_READ: begin
                        if (i_stat.pos_bad) begin
                            cmd.st_code = ST_BADPOS;
                        end else begin
                            cmd.rd_en = 1'b1;
                            cmd.ra    = RA_POS;
                        end
                    end
                    OP_WRITE: begin
                        if (i_stat.pos_bad) begin
                            cmd.st_code = ST_BADPOS;
                        end else begin
                            cmd.wr = WR_POS;
                        end
                    end
                    default: cmd.st_code = ST_OK;
                endcase
            end

            // stream reads forward; compare each one when its registered read data arrives
            S_SEARCH: begin
                if (i_stat.pend && i_stat.hit) begin
                    cmd.place = PL_TAG;
                    cmd.ptr   = PTR_COUNT;
                    n_state   = S_SHUP;
                end else if ((i_stat.pend && i_stat.tag_last) ||
                             (!i_stat.pend && !i_stat.more_fwd)) begin
                    cmd.place = PL_COUNT;
                    n_state   = S_PLACE;
                end else if (i_stat.more_fwd) begin
                    cmd.rd_en = 1'b1;
                    cmd.ra    = RA_PTR;
                    cmd.ptr   = PTR_INC;
                end
            end

            // move entries up from the top down; the last read drains as we leave
            S_SHUP: begin
                cmd.wr = WR_UP;
                if (i_stat.more_up) begin
                    cmd.rd_en = 1'b1;
                    cmd.ra    = RA_PTR_M1;
                    cmd.ptr   = PTR_DEC;
                end else begin
                    n_state = S_PLACE;
                end
            end

            S_SHDN: begin
                cmd.wr = WR_DN;
                if (i_stat.more_fwd) begin
                    cmd.rd_en = 1'b1;
                    cmd.ra    = RA_PTR;
                    cmd.ptr   = PTR_INC;
                end else begin
                    cmd.cnt = CNT_DEC;
                    n_state = S_FINISH;
                end
            end

            S_PLACE: begin
                cmd.wr  = WR_PLACE;
                cmd.cnt = CNT_INC;
                n_state = S_FINISH;
            end

            S_FINISH: begin
                cmd.emit = 1'b1;
                n_busy   = 1'b0;
                n_state  = S_IDLE;
            end

            default: begin
                n_busy  = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

endmodule
